>>> sv/source_token_lexer_top_macros.svh
// ----------------------------------------------------------------------------
// Source token lexer assertion macros
// Clocked assertion shorthands shared by the lexer RTL files.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKEN_LEXER_TOP_MACROS_SVH
`define SOURCE_TOKEN_LEXER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked on every rising clk_i edge outside reset.
`define STL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define STL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STL_ASSERT(lbl, prop, msg)
`define STL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/stl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source token lexer package
// Token kinds, error codes, lexer modes and the beat/bundle types.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned CNT_W       = 2;

  typedef enum logic [4:0] {
    K_EOF     = 5'd0,
    K_IDENT   = 5'd1,
    K_NUMBER  = 5'd2,
    K_STRING  = 5'd3,
    K_DOT     = 5'd4,
    K_COMMA   = 5'd5,
    K_AT      = 5'd6,
    K_LBRACE  = 5'd7,
    K_RBRACE  = 5'd8,
    K_LBRACK  = 5'd9,
    K_RBRACK  = 5'd10,
    K_LPAREN  = 5'd11,
    K_RPAREN  = 5'd12,
    K_PLUS    = 5'd13,
    K_STAR    = 5'd14,
    K_SLASH   = 5'd15,
    K_PERCENT = 5'd16,
    K_COLON   = 5'd17,
    K_DCOLON  = 5'd18,
    K_ASSIGN  = 5'd19,
    K_ARROW   = 5'd20,
    K_MINUS   = 5'd21,
    K_LT      = 5'd22,
    K_LE      = 5'd23,
    K_GT      = 5'd24,
    K_GE      = 5'd25,
    K_EQEQ    = 5'd26,
    K_NE      = 5'd27,
    K_ANDAND  = 5'd28,
    K_OROR    = 5'd29,
    K_PIPE    = 5'd30,
    K_ERROR   = 5'd31
  } kind_e;

  typedef enum logic [1:0] {
    E_NONE     = 2'd0,
    E_OVERFLOW = 2'd1,
    E_STRING   = 2'd2,
    E_TOKEN    = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    M_IDLE     = 4'd0,
    M_SEMI     = 4'd1,
    M_COMMENT  = 4'd2,
    M_IDENT    = 4'd3,
    M_NUMBER   = 4'd4,
    M_STR_OPEN = 4'd5,
    M_STR_BODY = 4'd6,
    M_COLON    = 4'd7,
    M_MINUS    = 4'd8,
    M_LESS     = 4'd9,
    M_GREATER  = 4'd10,
    M_EQ       = 4'd11,
    M_BANG     = 4'd12,
    M_AMP      = 4'd13,
    M_PIPE     = 4'd14
  } mode_e;

  // One input beat as held in the input register.
  typedef struct packed {
    logic [7:0] src_byte;
    logic       byte_valid;
    logic       eoi;
  } item_t;

  // One token result.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] offset;
    logic [31:0] length;
    logic [31:0] number;
    logic [31:0] line;
    logic [31:0] column;
    err_e        err;
  } res_t;

  // All results caused by one input beat.
  typedef struct packed {
    logic [CNT_W-1:0]              cnt;
    res_t [MAX_RESULTS-1:0]        slot;
  } bundle_t;

endpackage

>>> sv/source_token_lexer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source token lexer
// Streams source bytes in and tokens (kind, position, value, error) out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one source byte per beat: tdata = byte, tuser = byte is
//   present (0 for an empty closing beat), tlast = end of the source text.
//   Master side gives one token per beat: tuser = token kind, tdata = offset,
//   length, number value, line, column, error code; tlast marks the final
//   token caused by one input beat.
//   An accepted beat shows its first token once it has passed the input
//   register and then the result register (two register stages).
//   Throughput: one input beat per cycle while each byte yields at most one
//   token and m_axis_tready stays high; a byte that yields k tokens holds
//   the input until the result register has sent all k, one per ready cycle.
//   After the tlast beat, every position counter and the error state return
//   to their reset values, so the next beat begins a fresh text.
//   Reset (rst_ni low) clears both stages and the lexer state; line and
//   column start at 1.
//   When the receiver stalls, the current token holds steady, the result
//   register stays full and backpressure reaches s_axis_tready once the
//   input register is also full; no data is lost.
// ----------------------------------------------------------------------------
module source_token_lexer_top import stl_pkg::*; #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] source_byte
  input  logic         s_axis_tuser,   // byte_valid
  input  logic         s_axis_tlast,   // end_of_input
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata,   // offset, length, number_value, line,
                                       // column, error_code, zero pad
  output logic [4:0]   m_axis_tuser,   // token kind
  output logic         m_axis_tlast    // last_result
);

  item_t   s_item;
  item_t   held_item;
  logic    held_valid;
  logic    out_ready;
  logic    take;
  bundle_t bundle;
  res_t    res;

  assign s_item.src_byte   = s_axis_tdata;
  assign s_item.byte_valid = s_axis_tuser;
  assign s_item.eoi        = s_axis_tlast;

  // Core fires when the input register is full and the result register frees.
  assign take = held_valid && out_ready;

  stl_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .take_i    (take),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  stl_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .item_i   (held_item),
    .bundle_o (bundle)
  );

  stl_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (take),
    .bundle_i     (bundle),
    .ready_o      (out_ready),
    .valid_o      (m_axis_tvalid),
    .beat_ready_i (m_axis_tready),
    .res_o        (res),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {6'd0, res.err, res.column, res.line, res.number,
                         res.length, res.offset};

endmodule

>>> sv/stl_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer input register
// Holds one input beat until the lexer core consumes it.
// ----------------------------------------------------------------------------
module stl_in_reg import stl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  item_t      s_item_i,
  input  logic       take_i,     // core consumes the held beat
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign s_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= s_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> sv/stl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer core
// Lexer state and the single-pass byte step producing up to three tokens.
// ----------------------------------------------------------------------------
`include "source_token_lexer_top_macros.svh"

module stl_core import stl_pkg::*; #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    take_i,
  input  item_t   item_i,
  output bundle_t bundle_o
);

  localparam int unsigned PW = POSITION_BITS;
  localparam logic [PW-1:0] PosOne = PW'(1);
  localparam logic [PW-1:0] PosTwo = PW'(2);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChBar   = 8'h7C;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic kind_e single_kind(logic [7:0] c);
    kind_e k;
    unique case (c)
      8'h2E:   k = K_DOT;
      8'h2C:   k = K_COMMA;
      8'h40:   k = K_AT;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h5B:   k = K_LBRACK;
      8'h5D:   k = K_RBRACK;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h2B:   k = K_PLUS;
      8'h2A:   k = K_STAR;
      8'h2F:   k = K_SLASH;
      8'h25:   k = K_PERCENT;
      default: k = K_EOF;   // not a single punctuator
    endcase
    return k;
  endfunction

  function automatic mode_e pair_mode(logic [7:0] c);
    mode_e m;
    unique case (c)
      8'h3A:   m = M_COLON;
      8'h2D:   m = M_MINUS;
      8'h3C:   m = M_LESS;
      8'h3E:   m = M_GREATER;
      8'h3D:   m = M_EQ;
      8'h21:   m = M_BANG;
      8'h26:   m = M_AMP;
      8'h7C:   m = M_PIPE;
      default: m = M_IDLE;
    endcase
    return m;
  endfunction

  function automatic logic [PW-1:0] sat_inc(logic [PW-1:0] x);
    return (x == '1) ? x : x + PosOne;
  endfunction

  function automatic logic [31:0] lo32(logic [PW-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[31:0];
  endfunction

  function automatic res_t mk_res(kind_e k, logic [PW-1:0] off, logic [PW-1:0] len,
                                  logic [31:0] num, logic [PW-1:0] ln,
                                  logic [PW-1:0] col, err_e e);
    res_t r;
    r.kind   = k;
    r.offset = lo32(off);
    r.length = lo32(len);
    r.number = num;
    r.line   = lo32(ln);
    r.column = lo32(col);
    r.err    = e;
    return r;
  endfunction

  function automatic bundle_t push(bundle_t bin, res_t r);
    bundle_t bo;
    bo = bin;
    if (bin.cnt != CNT_W'(MAX_RESULTS)) begin
      bo.slot[bin.cnt] = r;
      bo.cnt           = bin.cnt + CNT_W'(1);
    end
    return bo;
  endfunction

  mode_e          mode_q, mode_d;
  logic [31:0]    acc_q, acc_d;
  logic [PW-1:0]  cur_off_q, cur_off_d, cur_line_q, cur_line_d, cur_col_q, cur_col_d;
  logic [PW-1:0]  st_off_q, st_off_d, st_line_q, st_line_d, st_col_q, st_col_d;
  logic           acr_q, acr_d;
  logic           failed_q, failed_d;
  bundle_t        bund_d;

  always_comb begin
    logic [7:0]    b;
    logic          cr_before;
    logic          do_idle;
    logic          do_fail;
    err_e          fcode;
    logic [7:0]    dv;
    logic [35:0]   prod;
    kind_e         sk;
    mode_e         pm;
    logic [PW-1:0] tlen;

    mode_d     = mode_q;
    acc_d      = acc_q;
    cur_off_d  = cur_off_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    st_off_d   = st_off_q;
    st_line_d  = st_line_q;
    st_col_d   = st_col_q;
    acr_d      = acr_q;
    failed_d   = failed_q;
    bund_d     = '0;

    b         = item_i.src_byte;
    cr_before = acr_q;
    do_idle   = 1'b0;
    do_fail   = 1'b0;
    fcode     = E_TOKEN;
    dv        = b - ChZero;
    prod      = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, dv[3:0]};
    sk        = single_kind(b);
    pm        = pair_mode(b);
    tlen      = cur_off_q - st_off_q;

    // ---- byte step ----
    if (!failed_q && item_i.byte_valid) begin
      acr_d = 1'b0;
      unique case (mode_q)
        M_SEMI: begin
          if (b == ChSemi) begin
            mode_d    = M_COMMENT;
            cur_off_d = sat_inc(cur_off_d);
            cur_col_d = sat_inc(cur_col_d);
          end else begin
            do_fail = 1'b1;
          end
        end
        M_COMMENT: begin
          if (b != ChCr && b != ChLf) begin
            cur_off_d = sat_inc(cur_off_d);
            cur_col_d = sat_inc(cur_col_d);
          end else begin
            mode_d  = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(b) || is_digit(b) || b == ChUnder) begin
            cur_off_d = sat_inc(cur_off_d);
            cur_col_d = sat_inc(cur_col_d);
          end else begin
            bund_d  = push(bund_d, mk_res(K_IDENT, st_off_q, tlen, '0, st_line_q,
                                          st_col_q, E_NONE));
            mode_d  = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(b)) begin
            if (prod[35:32] != 4'd0) begin
              do_fail = 1'b1;
              fcode   = E_OVERFLOW;
            end else begin
              acc_d     = prod[31:0];
              cur_off_d = sat_inc(cur_off_d);
              cur_col_d = sat_inc(cur_col_d);
            end
          end else begin
            bund_d  = push(bund_d, mk_res(K_NUMBER, st_off_q, tlen, acc_q, st_line_q,
                                          st_col_q, E_NONE));
            mode_d  = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_STR_OPEN: begin
          if (is_hex(b)) begin
            mode_d    = M_STR_BODY;
            cur_off_d = sat_inc(cur_off_d);
            cur_col_d = sat_inc(cur_col_d);
          end else begin
            do_fail = 1'b1;
            fcode   = E_STRING;
          end
        end
        M_STR_BODY: begin
          if (is_hex(b)) begin
            cur_off_d = sat_inc(cur_off_d);
            cur_col_d = sat_inc(cur_col_d);
          end else if (b == ChQuote) begin
            // text excludes both quotes
            bund_d    = push(bund_d, mk_res(K_STRING, sat_inc(st_off_q), tlen - PosOne,
                                            '0, st_line_q, st_col_q, E_NONE));
            mode_d    = M_IDLE;
            cur_off_d = sat_inc(cur_off_d);
            cur_col_d = sat_inc(cur_col_d);
          end else begin
            do_fail = 1'b1;
            fcode   = E_STRING;
          end
        end
        M_COLON: begin
          if (b == ChColon || b == ChEq) begin
            cur_off_d = sat_inc(cur_off_d);
            cur_col_d = sat_inc(cur_col_d);
            bund_d    = push(bund_d, mk_res((b == ChColon) ? K_DCOLON : K_ASSIGN,
                                            st_off_q, PosTwo, '0, st_line_q, st_col_q,
                                            E_NONE));
            mode_d    = M_IDLE;
          end else begin
            bund_d  = push(bund_d, mk_res(K_COLON, st_off_q, PosOne, '0, st_line_q,
                                          st_col_q, E_NONE));
            mode_d  = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_MINUS: begin
          if (b == ChGt) begin
            cur_off_d = sat_inc(cur_off_d);
            cur_col_d = sat_inc(cur_col_d);
            bund_d    = push(bund_d, mk_res(K_ARROW, st_off_q, PosTwo, '0, st_line_q,
                                            st_col_q, E_NONE));
            mode_d    = M_IDLE;
          end else begin
            bund_d  = push(bund_d, mk_res(K_MINUS, st_off_q, PosOne, '0, st_line_q,
                                          st_col_q, E_NONE));
            mode_d  = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_LESS, M_GREATER: begin
          if (b == ChEq) begin
            cur_off_d = sat_inc(cur_off_d);
            cur_col_d = sat_inc(cur_col_d);
            bund_d    = push(bund_d, mk_res((mode_q == M_LESS) ? K_LE : K_GE, st_off_q,
                                            PosTwo, '0, st_line_q, st_col_q, E_NONE));
            mode_d    = M_IDLE;
          end else begin
            bund_d  = push(bund_d, mk_res((mode_q == M_LESS) ? K_LT : K_GT, st_off_q,
                                          PosOne, '0, st_line_q, st_col_q, E_NONE));
            mode_d  = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_EQ, M_BANG: begin
          if (b == ChEq) begin
            cur_off_d = sat_inc(cur_off_d);
            cur_col_d = sat_inc(cur_col_d);
            bund_d    = push(bund_d, mk_res((mode_q == M_EQ) ? K_EQEQ : K_NE, st_off_q,
                                            PosTwo, '0, st_line_q, st_col_q, E_NONE));
            mode_d    = M_IDLE;
          end else begin
            do_fail = 1'b1;
          end
        end
        M_AMP: begin
          if (b == ChAmp) begin
            cur_off_d = sat_inc(cur_off_d);
            cur_col_d = sat_inc(cur_col_d);
            bund_d    = push(bund_d, mk_res(K_ANDAND, st_off_q, PosTwo, '0, st_line_q,
                                            st_col_q, E_NONE));
            mode_d    = M_IDLE;
          end else begin
            do_fail = 1'b1;
          end
        end
        M_PIPE: begin
          if (b == ChBar) begin
            cur_off_d = sat_inc(cur_off_d);
            cur_col_d = sat_inc(cur_col_d);
            bund_d    = push(bund_d, mk_res(K_OROR, st_off_q, PosTwo, '0, st_line_q,
                                            st_col_q, E_NONE));
            mode_d    = M_IDLE;
          end else begin
            bund_d  = push(bund_d, mk_res(K_PIPE, st_off_q, PosOne, '0, st_line_q,
                                          st_col_q, E_NONE));
            mode_d  = M_IDLE;
            do_idle = 1'b1;
          end
        end
        default: begin
          mode_d  = M_IDLE;
          do_idle = 1'b1;
        end
      endcase

      if (do_fail) begin
        bund_d   = push(bund_d, mk_res(K_ERROR, st_off_q, '0, '0, st_line_q, st_col_q,
                                       fcode));
        failed_d = 1'b1;
        mode_d   = M_IDLE;
      end

      // byte seen with nothing pending
      if (do_idle) begin
        if (b == ChSpace || b == ChTab) begin
          cur_off_d = sat_inc(cur_off_d);
          cur_col_d = sat_inc(cur_col_d);
        end else if (b == ChCr || b == ChLf) begin
          cur_off_d = sat_inc(cur_off_d);
          if (!(b == ChLf && cr_before)) begin
            cur_line_d = sat_inc(cur_line_d);
            cur_col_d  = PosOne;
          end
          acr_d = (b == ChCr);
        end else begin
          st_off_d  = cur_off_d;
          st_line_d = cur_line_d;
          st_col_d  = cur_col_d;
          if (b == ChSemi) begin
            mode_d = M_SEMI;
          end else if (is_alpha(b) || b == ChUnder) begin
            mode_d = M_IDENT;
          end else if (is_digit(b)) begin
            mode_d = M_NUMBER;
            acc_d  = {28'd0, dv[3:0]};
          end else if (b == ChQuote) begin
            mode_d = M_STR_OPEN;
          end else if (sk != K_EOF) begin
            bund_d = push(bund_d, mk_res(sk, st_off_d, PosOne, '0, st_line_d, st_col_d,
                                         E_NONE));
            mode_d = M_IDLE;
          end else if (pm != M_IDLE) begin
            mode_d = pm;
          end else begin
            bund_d   = push(bund_d, mk_res(K_ERROR, st_off_d, '0, '0, st_line_d,
                                           st_col_d, E_TOKEN));
            failed_d = 1'b1;
            mode_d   = M_IDLE;
          end
          if (!failed_d) begin
            cur_off_d = sat_inc(cur_off_d);
            cur_col_d = sat_inc(cur_col_d);
          end
        end
      end
    end

    // ---- end of text: flush, EOF, back to reset state ----
    if (item_i.eoi) begin
      if (!failed_d) begin
        tlen = cur_off_d - st_off_d;
        unique case (mode_d)
          M_IDENT:
            bund_d = push(bund_d, mk_res(K_IDENT, st_off_d, tlen, '0, st_line_d,
                                         st_col_d, E_NONE));
          M_NUMBER:
            bund_d = push(bund_d, mk_res(K_NUMBER, st_off_d, tlen, acc_d, st_line_d,
                                         st_col_d, E_NONE));
          M_STR_OPEN, M_STR_BODY: begin
            bund_d   = push(bund_d, mk_res(K_ERROR, st_off_d, '0, '0, st_line_d,
                                           st_col_d, E_STRING));
            failed_d = 1'b1;
          end
          M_SEMI, M_EQ, M_BANG, M_AMP: begin
            bund_d   = push(bund_d, mk_res(K_ERROR, st_off_d, '0, '0, st_line_d,
                                           st_col_d, E_TOKEN));
            failed_d = 1'b1;
          end
          M_COLON:
            bund_d = push(bund_d, mk_res(K_COLON, st_off_d, PosOne, '0, st_line_d,
                                         st_col_d, E_NONE));
          M_MINUS:
            bund_d = push(bund_d, mk_res(K_MINUS, st_off_d, PosOne, '0, st_line_d,
                                         st_col_d, E_NONE));
          M_LESS:
            bund_d = push(bund_d, mk_res(K_LT, st_off_d, PosOne, '0, st_line_d,
                                         st_col_d, E_NONE));
          M_GREATER:
            bund_d = push(bund_d, mk_res(K_GT, st_off_d, PosOne, '0, st_line_d,
                                         st_col_d, E_NONE));
          M_PIPE:
            bund_d = push(bund_d, mk_res(K_PIPE, st_off_d, PosOne, '0, st_line_d,
                                         st_col_d, E_NONE));
          default: ;
        endcase
        if (!failed_d) begin
          bund_d = push(bund_d, mk_res(K_EOF, cur_off_d, '0, '0, cur_line_d, cur_col_d,
                                       E_NONE));
        end
      end
      mode_d     = M_IDLE;
      acc_d      = '0;
      cur_off_d  = '0;
      cur_line_d = PosOne;
      cur_col_d  = PosOne;
      st_off_d   = '0;
      st_line_d  = PosOne;
      st_col_d   = PosOne;
      acr_d      = 1'b0;
      failed_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_IDLE;
      acc_q      <= '0;
      cur_off_q  <= '0;
      cur_line_q <= PosOne;
      cur_col_q  <= PosOne;
      st_off_q   <= '0;
      st_line_q  <= PosOne;
      st_col_q   <= PosOne;
      acr_q      <= 1'b0;
      failed_q   <= 1'b0;
    end else if (take_i) begin
      mode_q     <= mode_d;
      acc_q      <= acc_d;
      cur_off_q  <= cur_off_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      st_off_q   <= st_off_d;
      st_line_q  <= st_line_d;
      st_col_q   <= st_col_d;
      acr_q      <= acr_d;
      failed_q   <= failed_d;
    end
  end

  assign bundle_o = bund_d;

  // after an error nothing is pending
  `STL_ASSERT(a_fail_idle, failed_q |-> mode_q == M_IDLE, "pending token after error")
  // line and column count from one
  `STL_ASSERT(a_pos_nz, cur_line_q != '0 && cur_col_q != '0, "line or column is zero")

endmodule

>>> sv/stl_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer result register
// Registers one result bundle and sends its tokens out one beat each.
// ----------------------------------------------------------------------------
`include "source_token_lexer_top_macros.svh"

module stl_out import stl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,        // bundle_i computed this cycle
  input  bundle_t bundle_i,
  output logic    ready_o,       // can take a bundle this cycle
  output logic    valid_o,
  input  logic    beat_ready_i,
  output res_t    res_o,
  output logic    last_o
);

  logic             valid_q, valid_d;
  bundle_t          bund_q;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             done;

  assign last_o  = (idx_q == bund_q.cnt - CNT_W'(1));
  assign done    = valid_q && beat_ready_i && last_o;
  assign ready_o = !valid_q || done;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i && bundle_i.cnt != '0) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (done) begin
      valid_d = 1'b0;
    end else if (valid_q && beat_ready_i) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && bundle_i.cnt != '0) begin
      bund_q <= bundle_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = bund_q.slot[idx_q];

  `STL_ASSERT(a_cnt_nz, valid_q |-> bund_q.cnt != '0, "empty bundle held")
  `STL_ASSERT(a_idx_rng, valid_q |-> idx_q < bund_q.cnt, "slot index past bundle")
  `STL_ASSERT_NEXT(a_stall_hold, valid_q && !beat_ready_i,
                   valid_q && $stable(idx_q), "stalled beat moved")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source token lexer testbench
// Streams source texts into the lexer one byte per beat and checks every token
// against an in-bench lexer model: directed corner cases first, then random
// texts under several idle and stall patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import stl_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT  = 20000;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef struct packed {
    res_t tok;
    logic last;
  } tok_beat_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;
  logic [4:0]   m_axis_tuser;
  logic         m_axis_tlast;

  // lexer model state
  mode_e       lx_mode;
  logic [31:0] lx_acc;
  logic [31:0] lx_off, lx_line, lx_col;
  logic [31:0] lx_st_off, lx_st_line, lx_st_col;
  logic        lx_after_cr;
  logic        lx_failed;

  tok_beat_t   lex_step_q[$];
  tok_beat_t   tok_expect_q[$];
  logic [7:0]  text_q[$];

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_len = 0;
  logic        hold_go = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;

  int          errors = 0;
  int          tokens_checked = 0;
  int          beats_in = 0;
  int          bytes_sent = 0;
  int          texts_sent = 0;
  int          input_stalls = 0;
  logic [31:0] kinds_seen = '0;

  string id_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string hex_chars = "0123456789abcdefABCDEF";
  string punct_tab [0:26] = '{".", ",", "@", "{", "}", "[", "]", "(", ")", "+", "*",
                              "/", "%", ":", "::", ":=", "->", "-", "<", "<=", ">",
                              ">=", "==", "!=", "&&", "||", "|"};

  source_token_lexer_top #(
    .POSITION_BITS(32)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Timeout at %0t with %0d tokens outstanding", $time, tok_expect_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Lexer model
  // --------------------------------------------------------------------------
  function automatic logic [31:0] sat_inc(logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_hex(logic [7:0] b);
    return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  // K_EOF means the byte is not a one-character punctuator
  function automatic kind_e single_kind(logic [7:0] b);
    case (b)
      ".": return K_DOT;
      ",": return K_COMMA;
      "@": return K_AT;
      "{": return K_LBRACE;
      "}": return K_RBRACE;
      "[": return K_LBRACK;
      "]": return K_RBRACK;
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      "+": return K_PLUS;
      "*": return K_STAR;
      "/": return K_SLASH;
      "%": return K_PERCENT;
      default: return K_EOF;
    endcase
  endfunction

  // first character of an operator that may take a second one
  function automatic mode_e pair_mode(logic [7:0] b);
    case (b)
      ":": return M_COLON;
      "-": return M_MINUS;
      "<": return M_LESS;
      ">": return M_GREATER;
      "=": return M_EQ;
      "!": return M_BANG;
      "&": return M_AMP;
      "|": return M_PIPE;
      default: return M_IDLE;
    endcase
  endfunction

  function automatic void lex_restart();
    lx_mode     = M_IDLE;
    lx_acc      = '0;
    lx_off      = '0;
    lx_line     = 32'd1;
    lx_col      = 32'd1;
    lx_st_off   = '0;
    lx_st_line  = 32'd1;
    lx_st_col   = 32'd1;
    lx_after_cr = 1'b0;
    lx_failed   = 1'b0;
  endfunction

  function automatic void lex_emit(kind_e k, logic [31:0] off, logic [31:0] len,
                                   logic [31:0] num, logic [31:0] ln, logic [31:0] col,
                                   err_e e);
    tok_beat_t t;
    t.tok.kind   = k;
    t.tok.offset = off;
    t.tok.length = len;
    t.tok.number = num;
    t.tok.line   = ln;
    t.tok.column = col;
    t.tok.err    = e;
    t.last       = 1'b0;
    lex_step_q.push_back(t);
  endfunction

  function automatic void lex_finish(kind_e k, logic [31:0] len, logic [31:0] num);
    lex_emit(k, lx_st_off, len, num, lx_st_line, lx_st_col, E_NONE);
    lx_mode = M_IDLE;
  endfunction

  function automatic void lex_fail(err_e e);
    lex_emit(K_ERROR, lx_st_off, '0, '0, lx_st_line, lx_st_col, e);
    lx_failed = 1'b1;
    lx_mode   = M_IDLE;
  endfunction

  function automatic void lex_advance();
    lx_off = sat_inc(lx_off);
    lx_col = sat_inc(lx_col);
  endfunction

  function automatic logic [31:0] lex_text_len();
    return lx_off - lx_st_off;
  endfunction

  // byte seen with nothing pending: skip blanks, start a token or fail
  function automatic void lex_idle_byte(logic [7:0] b, logic cr_before);
    kind_e k;
    if (b == " " || b == CH_TAB) begin
      lex_advance();
      return;
    end
    if (b == CH_CR || b == CH_LF) begin
      lx_off = sat_inc(lx_off);
      if (!(b == CH_LF && cr_before)) begin
        lx_line = sat_inc(lx_line);
        lx_col  = 32'd1;
      end
      lx_after_cr = (b == CH_CR);
      return;
    end
    lx_st_off  = lx_off;
    lx_st_line = lx_line;
    lx_st_col  = lx_col;
    k = single_kind(b);
    if (b == CH_SEMI) begin
      lx_mode = M_SEMI;
    end else if (is_alpha(b) || b == "_") begin
      lx_mode = M_IDENT;
    end else if (is_digit(b)) begin
      lx_mode = M_NUMBER;
      lx_acc  = {24'd0, b - 8'h30};
    end else if (b == CH_QUOTE) begin
      lx_mode = M_STR_OPEN;
    end else if (k != K_EOF) begin
      lex_finish(k, 32'd1, '0);
    end else if (pair_mode(b) != M_IDLE) begin
      lx_mode = pair_mode(b);
    end else begin
      lex_fail(E_TOKEN);
      return;
    end
    lex_advance();
  endfunction

  function automatic void lex_take_byte(logic [7:0] b);
    logic        cr_before;
    logic [31:0] d;
    cr_before   = lx_after_cr;
    lx_after_cr = 1'b0;
    case (lx_mode)
      M_SEMI: begin
        if (b == CH_SEMI) begin
          lx_mode = M_COMMENT;
          lex_advance();
          return;
        end
        lex_fail(E_TOKEN);
        return;
      end
      M_COMMENT: begin
        if (b != CH_CR && b != CH_LF) begin
          lex_advance();
          return;
        end
        lx_mode = M_IDLE;
      end
      M_IDENT: begin
        if (is_alpha(b) || is_digit(b) || b == "_") begin
          lex_advance();
          return;
        end
        lex_finish(K_IDENT, lex_text_len(), '0);
      end
      M_NUMBER: begin
        if (is_digit(b)) begin
          d = {24'd0, b - 8'h30};
          // next digit would pass the 32-bit maximum
          if (lx_acc > (32'hFFFF_FFFF - d) / 32'd10) begin
            lex_fail(E_OVERFLOW);
            return;
          end
          lx_acc = lx_acc * 32'd10 + d;
          lex_advance();
          return;
        end
        lex_finish(K_NUMBER, lex_text_len(), lx_acc);
      end
      M_STR_OPEN: begin
        if (is_hex(b)) begin
          lx_mode = M_STR_BODY;
          lex_advance();
          return;
        end
        lex_fail(E_STRING);
        return;
      end
      M_STR_BODY: begin
        if (is_hex(b)) begin
          lex_advance();
          return;
        end
        if (b == CH_QUOTE) begin
          // quotes are not part of the reported text
          lex_emit(K_STRING, sat_inc(lx_st_off), lex_text_len() - 32'd1, '0,
                   lx_st_line, lx_st_col, E_NONE);
          lx_mode = M_IDLE;
          lex_advance();
          return;
        end
        lex_fail(E_STRING);
        return;
      end
      M_COLON: begin
        if (b == ":") begin
          lex_advance();
          lex_finish(K_DCOLON, 32'd2, '0);
          return;
        end
        if (b == "=") begin
          lex_advance();
          lex_finish(K_ASSIGN, 32'd2, '0);
          return;
        end
        lex_finish(K_COLON, 32'd1, '0);
      end
      M_MINUS: begin
        if (b == ">") begin
          lex_advance();
          lex_finish(K_ARROW, 32'd2, '0);
          return;
        end
        lex_finish(K_MINUS, 32'd1, '0);
      end
      M_LESS, M_GREATER: begin
        if (b == "=") begin
          lex_advance();
          if (lx_mode == M_LESS) lex_finish(K_LE, 32'd2, '0);
          else lex_finish(K_GE, 32'd2, '0);
          return;
        end
        if (lx_mode == M_LESS) lex_finish(K_LT, 32'd1, '0);
        else lex_finish(K_GT, 32'd1, '0);
      end
      M_EQ, M_BANG: begin
        if (b == "=") begin
          lex_advance();
          if (lx_mode == M_EQ) lex_finish(K_EQEQ, 32'd2, '0);
          else lex_finish(K_NE, 32'd2, '0);
          return;
        end
        lex_fail(E_TOKEN);
        return;
      end
      M_AMP: begin
        if (b == "&") begin
          lex_advance();
          lex_finish(K_ANDAND, 32'd2, '0);
          return;
        end
        lex_fail(E_TOKEN);
        return;
      end
      M_PIPE: begin
        if (b == "|") begin
          lex_advance();
          lex_finish(K_OROR, 32'd2, '0);
          return;
        end
        lex_finish(K_PIPE, 32'd1, '0);
      end
      default: begin
        lx_mode = M_IDLE;
      end
    endcase
    lex_idle_byte(b, cr_before);
  endfunction

  // end of text: flush what is pending, then EOF unless the text failed
  function automatic void lex_end_text();
    case (lx_mode)
      M_IDENT:                     lex_finish(K_IDENT, lex_text_len(), '0);
      M_NUMBER:                    lex_finish(K_NUMBER, lex_text_len(), lx_acc);
      M_STR_OPEN, M_STR_BODY:      lex_fail(E_STRING);
      M_SEMI, M_EQ, M_BANG, M_AMP: lex_fail(E_TOKEN);
      M_COLON:                     lex_finish(K_COLON, 32'd1, '0);
      M_MINUS:                     lex_finish(K_MINUS, 32'd1, '0);
      M_LESS:                      lex_finish(K_LT, 32'd1, '0);
      M_GREATER:                   lex_finish(K_GT, 32'd1, '0);
      M_PIPE:                      lex_finish(K_PIPE, 32'd1, '0);
      default:                     lx_mode = M_IDLE;
    endcase
    if (!lx_failed) lex_emit(K_EOF, lx_off, '0, '0, lx_line, lx_col, E_NONE);
  endfunction

  // one accepted input beat: queue the tokens it must produce
  function automatic void lex_beat(logic [7:0] b, logic valid, logic eoi);
    tok_beat_t t;
    lex_step_q.delete();
    if (!lx_failed && valid) lex_take_byte(b);
    if (eoi) begin
      if (!lx_failed) lex_end_text();
      lex_restart();
    end
    foreach (lex_step_q[i]) begin
      t      = lex_step_q[i];
      t.last = (i == lex_step_q.size() - 1);
      tok_expect_q.push_back(t);
    end
  endfunction

  function automatic string tok_str(res_t t, logic last);
    return $sformatf("kind=%0d off=%0d len=%0d num=%0d line=%0d col=%0d err=%0d last=%0b",
                     t.kind, t.offset, t.length, t.number, t.line, t.column, t.err, last);
  endfunction

  // --------------------------------------------------------------------------
  // Token checker and input monitor, both sampled at the same edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : token_check
    tok_beat_t want;
    res_t      got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind   = kind_e'(m_axis_tuser);
        got.offset = m_axis_tdata[31:0];
        got.length = m_axis_tdata[63:32];
        got.number = m_axis_tdata[95:64];
        got.line   = m_axis_tdata[127:96];
        got.column = m_axis_tdata[159:128];
        got.err    = err_e'(m_axis_tdata[161:160]);
        if (tok_expect_q.size() == 0) begin
          errors++;
          $display("%0t: token with none expected: expected none, actual %s",
                   $time, tok_str(got, m_axis_tlast));
        end else begin
          want = tok_expect_q.pop_front();
          tokens_checked++;
          kinds_seen[got.kind] = 1'b1;
          if (got !== want.tok || m_axis_tlast !== want.last) begin
            errors++;
            $display("%0t: token mismatch: expected %s", $time, tok_str(want.tok, want.last));
            $display("%0t:                 actual   %s", $time, tok_str(got, m_axis_tlast));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beats_in++;
        lex_beat(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      end
      if (s_axis_tvalid && !s_axis_tready) input_stalls++;
    end
  end

  // token sink: random stalls, or a counted hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen     <= hold_go;
      hold_left     <= hold_len;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic send_beat(logic [7:0] b, logic valid, logic eoi);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= valid;
    s_axis_tlast  <= eoi;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (valid) bytes_sent++;
  endtask

  // sends text_q; the end mark rides on the last byte or on an empty beat
  task automatic send_text(bit close_apart);
    foreach (text_q[i]) begin
      if ($urandom_range(19) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(text_q[i], 1'b1, !close_apart && (i == text_q.size() - 1));
    end
    if (close_apart || text_q.size() == 0) send_beat(8'($urandom), 1'b0, 1'b1);
    texts_sent++;
    text_q.delete();
  endtask

  // sender pauses until every expected token is out or the wait limit is reached
  task automatic drain();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tok_expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void put_token();
    logic [31:0] v;
    case ($urandom_range(5))
      0, 1: begin
        text_q.push_back(id_chars[$urandom_range(52)]);
        repeat ($urandom_range(5)) text_q.push_back(id_chars[$urandom_range(62)]);
      end
      2: begin
        case ($urandom_range(3))
          0:       v = $urandom;
          1:       v = 32'hFFFF_FFFF - $urandom_range(20);
          default: v = $urandom_range(999);
        endcase
        put_str($sformatf("%0d", v));
      end
      3: begin
        text_q.push_back(CH_QUOTE);
        repeat ($urandom_range(1, 6)) text_q.push_back(hex_chars[$urandom_range(21)]);
        text_q.push_back(CH_QUOTE);
      end
      default: put_str(punct_tab[$urandom_range(26)]);
    endcase
  endfunction

  // malformed input: overflow, stray operator starts, bad strings, raw noise
  function automatic void put_broken();
    logic [63:0] big;
    case ($urandom_range(5))
      0: begin
        big = 64'h1_0000_0000 + $urandom_range(2000000);
        put_str($sformatf("%0d", big));
      end
      1: begin
        text_q.push_back(CH_SEMI);
        text_q.push_back(8'($urandom));
      end
      2: begin
        case ($urandom_range(2))
          0:       text_q.push_back("=");
          1:       text_q.push_back("!");
          default: text_q.push_back("&");
        endcase
        text_q.push_back(8'($urandom));
      end
      3: begin
        text_q.push_back(CH_QUOTE);
        repeat ($urandom_range(3)) text_q.push_back(hex_chars[$urandom_range(21)]);
        text_q.push_back(8'($urandom));
      end
      default: text_q.push_back(8'($urandom));
    endcase
  endfunction

  function automatic void put_separator();
    logic [7:0] c;
    case ($urandom_range(6))
      0, 1: put_str(" ");
      2:    text_q.push_back(CH_TAB);
      3:    text_q.push_back(CH_LF);
      4: begin
        text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
      end
      5:    text_q.push_back(CH_CR);
      default: begin
        // comment body may carry any byte but a line break
        put_str(";;");
        repeat ($urandom_range(6)) begin
          do c = 8'($urandom); while (c == CH_CR || c == CH_LF);
          text_q.push_back(c);
        end
        text_q.push_back(CH_LF);
      end
    endcase
  endfunction

  function automatic void build_text(bit noisy, int ntok);
    repeat (ntok) begin
      if (noisy && $urandom_range(4) == 0) put_broken();
      else put_token();
      if ($urandom_range(9) < 6) put_separator();
    end
  endfunction

  // empty beats, empty text, largest number, overflow, line breaks
  task automatic test_limits();
    send_beat(8'hA5, 1'b0, 1'b0);
    send_text(1'b1);
    put_str("4294967295");
    send_text(1'b0);
    put_str("4294967296");
    send_text(1'b0);
    put_str("x");
    text_q.push_back(CH_CR);
    text_q.push_back(CH_LF);
    text_q.push_back(CH_CR);
    put_str("y");
    send_text(1'b1);
    drain();
  endtask

  // token and string error paths, and bytes dropped once a text has failed
  task automatic test_error_paths();
    text_q.push_back(8'hFF);
    text_q.push_back(8'h00);
    send_text(1'b0);
    put_str(";x");
    send_text(1'b0);
    put_str("a=b");
    send_text(1'b0);
    put_str("!");
    send_text(1'b0);
    put_str("&|");
    send_text(1'b0);
    text_q.push_back(CH_QUOTE);
    text_q.push_back(CH_QUOTE);
    send_text(1'b0);
    text_q.push_back(CH_QUOTE);
    put_str("0f");
    send_text(1'b0);
    drain();
  endtask

  task automatic test_stream_phase(int idle_pct, int stall_in, int n_bytes);
    int start;
    send_idle_pct = idle_pct;
    stall_pct     = stall_in;
    start         = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      build_text($urandom_range(3) == 0, $urandom_range(2, 10));
      send_text(1'($urandom_range(1)));
    end
    drain();
  endtask

  // sink holds off while the source keeps offering, so the input backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_len      <= 300;
    hold_go       <= ~hold_go;
    build_text(1'b0, 8);
    send_text(1'b0);
    drain();
  endtask

  initial begin
    lex_restart();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_limits();
    test_error_paths();
    test_stream_phase(0, 0, 30);
    test_stream_phase(74, 0, 30);
    test_stream_phase(0, 74, 30);
    test_stream_phase(26, 26, 30);
    test_backpressure();

    if (tok_expect_q.size() != 0) begin
      errors += tok_expect_q.size();
      $display("%0t: %0d expected tokens never came out, next expected %s", $time,
               tok_expect_q.size(), tok_str(tok_expect_q[0].tok, tok_expect_q[0].last));
    end
    $display("Covered %0d texts, %0d input beats (%0d bytes), %0d tokens checked",
             texts_sent, beats_in, bytes_sent, tokens_checked);
    $display("Token kinds seen: %0d of 32; input held back for %0d cycles",
             $countones(kinds_seen), input_stalls);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
